/* design/mfs_pkg.sv */
// Package for the mesh facet statistics unit: beat types, sequencer states,
// multiplier control and the fixed widths and step counts of the datapath.
// No dependencies.
package mfs_pkg;

    localparam int FC_W       = 24;   // facet_count and triangle index width
    localparam int MUL_W      = 65;   // serial multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int N_MUL      = 9;    // six cross products, three height terms
    localparam int CNT_W      = 7;

    localparam int MUL_STEPS  = 32;   // 32 x 32 magnitude products
    localparam int SQ_STEPS   = MUL_W;
    localparam int ROOT_STEPS = 49;   // root of a 98-bit radicand
    localparam int AREA_STEPS = 49;   // area width
    localparam int DIV_STEPS  = 34;   // two quotient bits per step
    localparam int Q_W        = 2 * DIV_STEPS;

    localparam int MUL_SH     = MUL_W - MUL_STEPS;
    localparam int AREA_SH    = MUL_W - AREA_STEPS;

    localparam logic [62:0] SAT63 = {63{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_CROSS,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_AREA,
        ST_PROD,
        ST_DVL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] vert0_x;
        logic signed [31:0] vert0_y;
        logic signed [31:0] vert0_z;
        logic signed [31:0] vert1_x;
        logic signed [31:0] vert1_y;
        logic signed [31:0] vert1_z;
        logic signed [31:0] vert2_x;
        logic signed [31:0] vert2_y;
        logic signed [31:0] vert2_z;
    } t_tri;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic [62:0]        surface_total;
        logic [62:0]        volume_total;
        logic               mesh_done;
    } t_res;

endpackage

/* design/mfs_if.sv */
// Channel interfaces of the mesh facet statistics unit: triangle input,
// result output and facet_count write port. Depends on mfs_pkg.
interface mfs_tri_if;
    logic          valid;
    logic          ready;
    mfs_pkg::t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mfs_res_if;
    logic          valid;
    logic          ready;
    mfs_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mfs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mfs_pkg::FC_W-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/mfs_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per step.
// After k steps the product sits at o_prod >> (MUL_W - k). Depends on mfs_pkg.
module mfs_mul (
    input  logic                           i_clk,
    input  mfs_pkg::t_mul_ctl              i_ctl,
    input  logic [mfs_pkg::MUL_W-1:0]      i_a,
    input  logic [mfs_pkg::MUL_W-1:0]      i_b,
    output logic [mfs_pkg::PROD_W-1:0]     o_prod
);
    import mfs_pkg::*;

    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [PROD_W-1:0] r_acc;
    logic [MUL_W:0]    w_sum;

    assign w_sum  = {1'b0, r_acc[PROD_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= {w_sum, r_acc[MUL_W-1:1]};
            r_b   <= r_b >> 1;
        end
    end
endmodule

/* design/mesh_facet_statistics_unit.sv */
// Mesh facet statistics unit: top level with sequencer and serial datapath.
// Depends on mfs_pkg, the mfs_*_if interfaces and mfs_mul.
//
// One triangle beat in, one result beat out. Each result carries the running
// bounding box, the saturating surface sum and the absolute saturating signed
// volume sum of the current mesh, plus mesh_done on the triangle that reaches
// facet_count (0 acts as 1); the next triangle then opens a new mesh and its
// first vertex becomes the reference point. After acceptance a triangle runs
// through the bit-serial chain: 32 steps for the edge cross products and
// height terms (nine serial multipliers in parallel), 65 steps for the three
// squares, 49 restoring square-root steps, 49 steps for area times height
// and 34 radix-4 steps of the divide by three, joined by the transfer states
// PREP, CROSS, SUM, AREA, DVL, FIN and OUT. One triangle is in work at a
// time; the next is taken as soon as the result moves to the output register,
// even if that beat is still waiting. facet_count is to be written by the
// user through i_cfg only at an idle moment; the block itself does not
// enforce it, and i_cfg is always ready.
module mesh_facet_statistics_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mfs_tri_if.sink  i_tri,
    mfs_cfg_if.sink  i_cfg,
    mfs_res_if.source o_res
);
    import mfs_pkg::*;

    function automatic logic [31:0] abs33(input logic signed [32:0] x);
        logic [32:0] m;
        m = x[32] ? -x : x;
        return m[31:0];
    endfunction

    // ---------------- state ----------------
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [FC_W-1:0]   r_fc;
    logic [FC_W-1:0]   r_idx;
    logic              r_done;
    logic signed [31:0] r_ref [3];
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic [62:0]       r_surf;
    logic signed [63:0] r_vol;
    logic              r_ov;
    t_res              r_out;

    // ---------------- payload ----------------
    logic signed [31:0] r_v [3][3];      // [vertex][axis]
    logic signed [15:0] r_n [3];
    logic [N_MUL-1:0]   r_sgn;           // product sign per multiplier
    logic [48:0]        r_hm;
    logic               r_hneg;
    logic [131:0]       r_s;             // square sum, then radicand shifter
    logic [49:0]        r_rem;
    logic [48:0]        r_root;
    logic [Q_W-1:0]     r_dx;
    logic [Q_W-1:0]     r_q;
    logic [1:0]         r_r3;

    // ---------------- multipliers ----------------
    logic [MUL_W-1:0]  w_ma [N_MUL];
    logic [MUL_W-1:0]  w_mb [N_MUL];
    t_mul_ctl          w_mc [N_MUL];
    logic [PROD_W-1:0] w_mp [N_MUL];

    for (genvar g = 0; g < N_MUL; g++) begin : g_mul
        mfs_mul u_mul (
            .i_clk  (i_clk),
            .i_ctl  (w_mc[g]),
            .i_a    (w_ma[g]),
            .i_b    (w_mb[g]),
            .o_prod (w_mp[g])
        );
    end

    // ---------------- accept side ----------------
    logic               w_acc, w_first, w_done, w_out_load;
    logic [FC_W-1:0]    w_fc;
    logic [FC_W:0]      w_idx1;
    logic signed [31:0] w_vin [3][3];
    logic signed [31:0] w_ref [3];
    logic signed [31:0] w_min [3];
    logic signed [31:0] w_max [3];

    assign w_acc   = i_tri.valid && i_tri.ready;
    assign w_first = (r_idx == '0);
    assign w_fc    = (r_fc == '0) ? FC_W'(1) : r_fc;
    assign w_idx1  = {1'b0, r_idx} + (FC_W+1)'(1);
    assign w_done  = (w_idx1 >= {1'b0, w_fc});

    always_comb begin
        w_vin[0][0] = i_tri.data.vert0_x;
        w_vin[0][1] = i_tri.data.vert0_y;
        w_vin[0][2] = i_tri.data.vert0_z;
        w_vin[1][0] = i_tri.data.vert1_x;
        w_vin[1][1] = i_tri.data.vert1_y;
        w_vin[1][2] = i_tri.data.vert1_z;
        w_vin[2][0] = i_tri.data.vert2_x;
        w_vin[2][1] = i_tri.data.vert2_y;
        w_vin[2][2] = i_tri.data.vert2_z;
        for (int i = 0; i < 3; i++) begin
            w_ref[i] = w_first ? w_vin[0][i] : r_ref[i];
            w_min[i] = w_first ? w_vin[0][i] : r_min[i];
            w_max[i] = w_first ? w_vin[0][i] : r_max[i];
            for (int k = 0; k < 3; k++) begin
                if (w_vin[k][i] < w_min[i]) w_min[i] = w_vin[k][i];
                if (w_vin[k][i] > w_max[i]) w_max[i] = w_vin[k][i];
            end
        end
    end

    // ---------------- prep: edges and height deltas ----------------
    logic signed [32:0] w_e1 [3];
    logic signed [32:0] w_e2 [3];
    logic signed [32:0] w_d  [3];
    logic [15:0]        w_nm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = {r_v[1][i][31], r_v[1][i]} - {r_v[0][i][31], r_v[0][i]};
            w_e2[i] = {r_v[2][i][31], r_v[2][i]} - {r_v[0][i][31], r_v[0][i]};
            w_d[i]  = {r_v[0][i][31], r_v[0][i]} - {r_ref[i][31], r_ref[i]};
            w_nm[i] = r_n[i][15] ? 16'(-r_n[i]) : r_n[i];
        end
    end

    // ---------------- cross components and height ----------------
    logic [63:0]        w_p  [N_MUL];
    logic signed [65:0] w_sp [6];
    logic signed [65:0] w_c  [3];
    logic [64:0]        w_cm [3];
    logic signed [49:0] w_hs;
    logic signed [49:0] w_ht;
    logic [49:0]        w_hmag;

    always_comb begin
        for (int i = 0; i < N_MUL; i++) w_p[i] = w_mp[i][MUL_SH+63:MUL_SH];
        for (int i = 0; i < 6; i++)
            w_sp[i] = r_sgn[i] ? -$signed({2'b00, w_p[i]}) : $signed({2'b00, w_p[i]});
        for (int k = 0; k < 3; k++) begin
            w_c[k]  = w_sp[2*k] - w_sp[2*k+1];
            w_cm[k] = w_c[k][65] ? 65'(-w_c[k]) : w_c[k][64:0];
        end
        w_hs = '0;
        for (int i = 6; i < N_MUL; i++) begin
            w_ht = $signed({2'b00, w_p[i][47:0]});
            w_hs = r_sgn[i] ? w_hs - w_ht : w_hs + w_ht;
        end
        w_hmag = w_hs[49] ? 50'(-w_hs) : w_hs;
    end

    // ---------------- root, divide, accumulate ----------------
    logic [51:0]     w_rv, w_rt, w_rd;
    logic [3:0]      w_dv;
    logic [1:0]      w_q2;
    logic [3:0]      w_dr;
    logic [Q_W-1:0]  w_x;
    logic [62:0]     w_term;
    logic [63:0]     w_ssum;
    logic signed [64:0] w_vs;
    logic [63:0]     w_vabs;

    assign w_rv = {r_rem, r_s[131:130]};
    assign w_rt = {1'b0, r_root, 2'b01};
    assign w_rd = w_rv - w_rt;
    assign w_dv = {r_r3, r_dx[Q_W-1:Q_W-2]};
    assign w_q2 = (w_dv >= 4'd9) ? 2'd3 : (w_dv >= 4'd6) ? 2'd2 :
                  (w_dv >= 4'd3) ? 2'd1 : 2'd0;
    assign w_dr = w_dv - {1'b0, w_q2, 1'b0} - {2'b00, w_q2};
    assign w_x  = w_mp[0][AREA_SH+30+Q_W-1:AREA_SH+30];
    assign w_term = (r_q[Q_W-1:63] != '0) ? SAT63 : r_q[62:0];
    assign w_ssum = {1'b0, r_surf} + {15'd0, r_root};
    assign w_vabs = r_vol[63] ? -r_vol : r_vol;

    always_comb begin
        if (!r_hneg) begin
            w_vs = {r_vol[63], r_vol} + $signed({2'b00, w_term});
            if (w_vs > $signed({2'b00, SAT63})) w_vs = $signed({2'b00, SAT63});
        end else begin
            w_vs = {r_vol[63], r_vol} - $signed({2'b00, w_term});
            if (w_vs < -$signed({2'b00, SAT63})) w_vs = -$signed({2'b00, SAT63});
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_tri.valid) n_state = ST_PREP;
            ST_PREP:  n_state = ST_MUL;
            ST_MUL:   if (r_cnt == CNT_W'(MUL_STEPS-1)) n_state = ST_CROSS;
            ST_CROSS: n_state = ST_SQ;
            ST_SQ:    if (r_cnt == CNT_W'(SQ_STEPS-1)) n_state = ST_SUM;
            ST_SUM:   if (r_cnt == CNT_W'(1)) n_state = ST_ROOT;
            ST_ROOT:  if (r_cnt == CNT_W'(ROOT_STEPS-1)) n_state = ST_AREA;
            ST_AREA:  n_state = ST_PROD;
            ST_PROD:  if (r_cnt == CNT_W'(AREA_STEPS-1)) n_state = ST_DVL;
            ST_DVL:   n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_W'(DIV_STEPS-1)) n_state = ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (!r_ov || o_res.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshakes and multiplier control
    always_comb begin
        i_tri.ready = (r_state == ST_IDLE);
        i_cfg.ready = 1'b1;
        w_out_load  = (r_state == ST_OUT) && (!r_ov || o_res.ready);
        for (int i = 0; i < N_MUL; i++) begin
            w_mc[i] = '0;
            w_ma[i] = '0;
            w_mb[i] = '0;
        end
        unique case (r_state)
            ST_PREP: begin
                w_ma[0] = {33'd0, abs33(w_e1[1])}; w_mb[0] = {33'd0, abs33(w_e2[2])};
                w_ma[1] = {33'd0, abs33(w_e1[2])}; w_mb[1] = {33'd0, abs33(w_e2[1])};
                w_ma[2] = {33'd0, abs33(w_e1[2])}; w_mb[2] = {33'd0, abs33(w_e2[0])};
                w_ma[3] = {33'd0, abs33(w_e1[0])}; w_mb[3] = {33'd0, abs33(w_e2[2])};
                w_ma[4] = {33'd0, abs33(w_e1[0])}; w_mb[4] = {33'd0, abs33(w_e2[1])};
                w_ma[5] = {33'd0, abs33(w_e1[1])}; w_mb[5] = {33'd0, abs33(w_e2[0])};
                for (int i = 0; i < 3; i++) begin
                    w_ma[6+i] = {33'd0, abs33(w_d[i])};
                    w_mb[6+i] = {49'd0, w_nm[i]};
                end
                for (int i = 0; i < N_MUL; i++) w_mc[i].load = 1'b1;
            end
            ST_MUL: begin
                for (int i = 0; i < N_MUL; i++) w_mc[i].step = 1'b1;
            end
            ST_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    w_ma[k] = w_cm[k];
                    w_mb[k] = w_cm[k];
                    w_mc[k].load = 1'b1;
                end
            end
            ST_SQ: begin
                for (int k = 0; k < 3; k++) w_mc[k].step = 1'b1;
            end
            ST_AREA: begin
                w_ma[0] = {16'd0, r_hm};
                w_mb[0] = {16'd0, r_root};
                w_mc[0].load = 1'b1;
            end
            ST_PROD: w_mc[0].step = 1'b1;
            default: ;
        endcase
    end

    // ---------------- control and mesh state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fc    <= FC_W'(1);
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_surf  <= '0;
            r_vol   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ref[i] <= '0;
                r_min[i] <= '0;
                r_max[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + CNT_W'(1);
            if (i_cfg.valid) r_fc <= i_cfg.data;
            if (w_acc) begin
                r_done <= w_done;
                r_idx  <= w_done ? '0 : w_idx1[FC_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    r_ref[i] <= w_ref[i];
                    r_min[i] <= w_min[i];
                    r_max[i] <= w_max[i];
                end
                if (w_first) begin
                    r_surf <= '0;
                    r_vol  <= '0;
                end
            end
            if (r_state == ST_AREA)
                r_surf <= (w_ssum > {1'b0, SAT63}) ? SAT63 : w_ssum[62:0];
            if (r_state == ST_FIN)
                r_vol <= w_vs[63:0];
            if (w_out_load)       r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    // ---------------- datapath payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_v   <= w_vin;
            r_n[0] <= i_tri.data.normal_x;
            r_n[1] <= i_tri.data.normal_y;
            r_n[2] <= i_tri.data.normal_z;
        end
        case (r_state)
            ST_PREP: begin
                r_sgn[0] <= w_e1[1][32] ^ w_e2[2][32];
                r_sgn[1] <= w_e1[2][32] ^ w_e2[1][32];
                r_sgn[2] <= w_e1[2][32] ^ w_e2[0][32];
                r_sgn[3] <= w_e1[0][32] ^ w_e2[2][32];
                r_sgn[4] <= w_e1[0][32] ^ w_e2[1][32];
                r_sgn[5] <= w_e1[1][32] ^ w_e2[0][32];
                for (int i = 0; i < 3; i++) r_sgn[6+i] <= w_d[i][32] ^ r_n[i][15];
            end
            ST_CROSS: begin
                r_hm   <= w_hmag[48:0];
                r_hneg <= w_hs[49];
            end
            ST_SUM: begin
                if (r_cnt == '0) r_s <= {2'b00, w_mp[0]} + {2'b00, w_mp[1]};
                else             r_s <= r_s + {2'b00, w_mp[2]};
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                if (w_rv >= w_rt) begin
                    r_rem  <= w_rd[49:0];
                    r_root <= {r_root[47:0], 1'b1};
                end else begin
                    r_rem  <= w_rv[49:0];
                    r_root <= {r_root[47:0], 1'b0};
                end
                r_s <= r_s << 2;
            end
            ST_DVL: begin
                r_dx <= w_x;
                r_r3 <= '0;
                r_q  <= '0;
            end
            ST_DIV: begin
                r_dx <= r_dx << 2;
                r_r3 <= w_dr[1:0];
                r_q  <= {r_q[Q_W-3:0], w_q2};
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.min_x         <= r_min[0];
            r_out.min_y         <= r_min[1];
            r_out.min_z         <= r_min[2];
            r_out.max_x         <= r_max[0];
            r_out.max_y         <= r_max[1];
            r_out.max_z         <= r_max[2];
            r_out.surface_total <= r_surf;
            r_out.volume_total  <= w_vabs[62:0];
            r_out.mesh_done     <= r_done;
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    // ---------------- assertions ----------------
    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == ST_PREP))
        else $error("accepted beat did not start the sequence");

    a_result_offered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_res.valid && r_state == ST_IDLE))
        else $error("finished result not offered");

    a_done_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_res.valid) && o_res.data.mesh_done) |-> (r_idx == '0))
        else $error("mesh_done without index restart");

    a_vol_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol != {1'b1, 63'd0})
        else $error("volume sum left its saturation range");
endmodule

/* tb/sv/testbench.sv */
// Testbench for mesh_facet_statistics_unit: triangle beats in, result beats out,
// each result checked against a built-in predictor of bounds, surface, volume and mesh_done.
// Depends on mfs_pkg, the mfs_*_if interfaces and the unit's RTL.
import mfs_pkg::*;

// Running mesh statistics predictor plus the queue of results still to arrive.
class mesh_stats_board;
    logic [FC_W-1:0]    facet_count;
    logic [FC_W-1:0]    tri_idx;
    logic signed [31:0] ref_pt [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic [62:0]        surface;
    logic signed [65:0] volume;
    t_res               results_due [$];
    int                 errors;

    function new();
        facet_count = 1;
        tri_idx     = 0;
        surface     = 0;
        volume      = 0;
        errors      = 0;
        foreach (ref_pt[i]) begin
            ref_pt[i] = 0;
            lo[i]     = 0;
            hi[i]     = 0;
        end
    endfunction

    function void set_count(logic [FC_W-1:0] v);
        facet_count = v;
    endfunction

    // Fold one triangle into the running state and queue the result it causes.
    function void note_triangle(t_tri t);
        logic signed [127:0] vx [3][3];
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [255:0] cr;
        logic [255:0]        sq_sum;
        logic [255:0]        cand;
        logic [255:0]        root;
        logic signed [63:0]  height;
        logic [63:0]         hmag;
        logic [127:0]        term;
        logic [FC_W:0]       next_idx;
        logic [FC_W-1:0]     fc;
        t_res                r;
        vx[0][0] = t.vert0_x; vx[0][1] = t.vert0_y; vx[0][2] = t.vert0_z;
        vx[1][0] = t.vert1_x; vx[1][1] = t.vert1_y; vx[1][2] = t.vert1_z;
        vx[2][0] = t.vert2_x; vx[2][1] = t.vert2_y; vx[2][2] = t.vert2_z;
        fc = (facet_count == '0) ? FC_W'(1) : facet_count;
        // first triangle of a mesh: new reference point, box and sums
        if (tri_idx == 0) begin
            for (int i = 0; i < 3; i++) begin
                ref_pt[i] = vx[0][i][31:0];
                lo[i]     = vx[0][i][31:0];
                hi[i]     = vx[0][i][31:0];
            end
            surface = 0;
            volume  = 0;
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) begin
                if (vx[k][i] < lo[i]) lo[i] = vx[k][i][31:0];
                if (vx[k][i] > hi[i]) hi[i] = vx[k][i][31:0];
            end
        for (int i = 0; i < 3; i++) begin
            e1[i] = vx[1][i] - vx[0][i];
            e2[i] = vx[2][i] - vx[0][i];
        end
        sq_sum = 0;
        for (int i = 0; i < 3; i++) begin
            cr = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
            sq_sum = sq_sum + $unsigned(cr * cr);
        end
        sq_sum = sq_sum >> 34;
        // area root is resolved over bits 49..0 only
        root = 0;
        for (int b = 49; b >= 0; b--) begin
            cand = root | (256'd1 << b);
            if (cand * cand <= sq_sum) root = cand;
        end
        surface = (65'(surface) + 65'(root[62:0]) > 65'(SAT63)) ? SAT63
                                                                 : surface + root[62:0];
        height = (64'(t.normal_x) * (64'(vx[0][0]) - 64'(ref_pt[0])))
               + (64'(t.normal_y) * (64'(vx[0][1]) - 64'(ref_pt[1])))
               + (64'(t.normal_z) * (64'(vx[0][2]) - 64'(ref_pt[2])));
        hmag = (height < 0) ? -height : height;
        term = (128'(root[63:0]) * 128'(hmag)) / (128'd3 << 30);
        if (term > 128'(SAT63)) term = 128'(SAT63);
        if (height >= 0) begin
            volume = volume + $signed({2'b00, term[63:0]});
            if (volume > $signed({3'b000, SAT63})) volume = {3'b000, SAT63};
        end else begin
            volume = volume - $signed({2'b00, term[63:0]});
            if (volume < -$signed({3'b000, SAT63})) volume = -$signed({3'b000, SAT63});
        end
        next_idx = {1'b0, tri_idx} + (FC_W+1)'(1);
        r.mesh_done = (next_idx >= {1'b0, fc});
        tri_idx = r.mesh_done ? '0 : next_idx[FC_W-1:0];
        r.min_x = lo[0]; r.min_y = lo[1]; r.min_z = lo[2];
        r.max_x = hi[0]; r.max_y = hi[1]; r.max_z = hi[2];
        r.surface_total = surface;
        r.volume_total  = (volume < 0) ? 63'(-volume) : volume[62:0];
        results_due = {results_due, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (beat %0d pending)",
                 what, got, want, results_due.size());
        errors++;
    endtask

    task check_result(t_res got);
        t_res w;
        if (results_due.size() == 0) begin
            report("unexpected result beat", 64'(got.surface_total), 64'd0);
            return;
        end
        w = results_due.pop_front();
        if (got.min_x != w.min_x) report("min_x", 64'(got.min_x), 64'(w.min_x));
        if (got.min_y != w.min_y) report("min_y", 64'(got.min_y), 64'(w.min_y));
        if (got.min_z != w.min_z) report("min_z", 64'(got.min_z), 64'(w.min_z));
        if (got.max_x != w.max_x) report("max_x", 64'(got.max_x), 64'(w.max_x));
        if (got.max_y != w.max_y) report("max_y", 64'(got.max_y), 64'(w.max_y));
        if (got.max_z != w.max_z) report("max_z", 64'(got.max_z), 64'(w.max_z));
        if (got.surface_total != w.surface_total)
            report("surface_total", 64'(got.surface_total), 64'(w.surface_total));
        if (got.volume_total != w.volume_total)
            report("volume_total", 64'(got.volume_total), 64'(w.volume_total));
        if (got.mesh_done != w.mesh_done)
            report("mesh_done", 64'(got.mesh_done), 64'(w.mesh_done));
    endtask
endclass

module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfs_tri_if tri_ch ();
    mfs_cfg_if cfg_ch ();
    mfs_res_if res_ch ();

    mesh_facet_statistics_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    mesh_stats_board board = new();
    int res_hold = 0;    // long receiver hold-off request, in cycles
    int sent = 0;

    always #5 i_clk = ~i_clk;

    // Result side: sampled at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);

    // Receiver stall pattern: switches between always-ready, coin-flip and
    // long-run stalls; a hold request blocks ready for that many cycles.
    initial begin
        int mode;
        int left;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 400);
            while (left > 0) begin
                @(negedge i_clk);
                if (res_hold > 0) begin
                    res_ch.ready <= 1'b0;
                    res_hold--;
                end else begin
                    case (mode)
                        0: res_ch.ready <= 1'b1;
                        1: res_ch.ready <= $urandom_range(0, 1);
                        default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    left--;
                end
            end
        end
    end

    // Leaves the task at the falling edge after the beat is taken, valid still high.
    task automatic send_tri(t_tri t);
        tri_ch.valid <= 1'b1;
        tri_ch.data  <= t;
        do @(posedge i_clk); while (!tri_ch.ready);
        board.note_triangle(t);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic tri_gap(int n);
        tri_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Wait for every queued result, then let the pipeline settle before a write.
    task automatic drain();
        tri_gap(1);
        while (board.results_due.size() != 0) @(negedge i_clk);
        repeat (260) @(negedge i_clk);
    endtask

    task automatic write_count(logic [FC_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_count(v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_tri make_tri(int nx, int ny, int nz,
                                      int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        t_tri t;
        t.normal_x = 16'(nx); t.normal_y = 16'(ny); t.normal_z = 16'(nz);
        t.vert0_x = ax;  t.vert0_y = ay;  t.vert0_z = az;
        t.vert1_x = bx;  t.vert1_y = by;  t.vert1_z = bz;
        t.vert2_x = cx;  t.vert2_y = cy;  t.vert2_z = cz;
        return t;
    endfunction

    // Mostly modest meshes around a random origin; some full-range noise and
    // degenerate triangles (repeated vertex, collinear points).
    function automatic t_tri random_tri(int base);
        t_tri         t;
        logic [351:0] noise;
        int           kind;
        int           span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 24);
        t.normal_x = 16'($urandom); t.normal_y = 16'($urandom); t.normal_z = 16'($urandom);
        if (kind == 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            t = noise[335:0];
        end else begin
            t.vert0_x = base + $urandom_range(0, span); t.vert0_y = base - $urandom_range(0, span);
            t.vert0_z = base + $urandom_range(0, span); t.vert1_x = base - $urandom_range(0, span);
            t.vert1_y = base + $urandom_range(0, span); t.vert1_z = base - $urandom_range(0, span);
            t.vert2_x = base + $urandom_range(0, span); t.vert2_y = base + $urandom_range(0, span);
            t.vert2_z = base - $urandom_range(0, span);
            if (kind == 1) begin
                t.vert2_x = t.vert0_x; t.vert2_y = t.vert0_y; t.vert2_z = t.vert0_z;
            end else if (kind == 2) begin
                t.vert2_x = 2 * t.vert1_x - t.vert0_x;
                t.vert2_y = 2 * t.vert1_y - t.vert0_y;
                t.vert2_z = 2 * t.vert1_z - t.vert0_z;
            end
        end
        return t;
    endfunction

    initial begin
        int mins;
        int maxs;
        logic [FC_W-1:0] counts [8];
        int burst;
        int base;
        mins   = 32'h8000_0000;
        maxs   = 32'h7fff_ffff;
        counts = '{24'd3, 24'd0, 24'hffffff, 24'd1, 24'd7, 24'd2, 24'd12, 24'd5};
        tri_ch.valid = 1'b0;
        tri_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, degenerate triangles, volume saturation.
        write_count(24'd4);
        send_tri(make_tri(16384, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        send_tri(make_tri(32767, 32767, 32767, maxs, maxs, maxs, mins, mins, mins,
                          maxs, mins, maxs));
        send_tri(make_tri(-32768, -32768, -32768, mins, mins, mins, maxs, mins, maxs,
                          mins, maxs, maxs));
        send_tri(make_tri(0, 0, 0, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        send_tri(make_tri(-32768, 0, 0, maxs, 0, 0, mins, maxs, 0, mins, 0, maxs));
        send_tri(make_tri(-32768, 32767, 0, mins, maxs, mins, maxs, mins, maxs,
                          mins, mins, mins));
        send_tri(make_tri(32767, -32768, 1, maxs, mins, maxs, mins, maxs, mins,
                          maxs, maxs, mins));
        send_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_tri(make_tri(16384, 16384, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_tri(make_tri(0, 0, 16384, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_tri(make_tri(0, 0, -16384, 65536, 65536, mins, 0, maxs, 0, maxs, 0, 0));
        send_tri(make_tri(0, 0, 16384, 0, 0, maxs, mins, 0, 0, 0, mins, 0));
        drain();

        // Random phases; each opens with a new facet_count while idle.
        for (int ph = 0; ph < 8; ph++) begin
            write_count(counts[ph]);
            if (ph == 2) res_hold = 1500;    // block fills and stalls its input
            base = $urandom;
            base = base >>> $urandom_range(1, 12);
            while (sent < 12 + (ph + 1) * 205) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst; b++) send_tri(random_tri(base));
                if ($urandom_range(0, 3) != 0) tri_gap($urandom_range(0, 300));
            end
            drain();
        end

        if (board.errors == 0)
            $display("mesh_facet_statistics_unit regression: pass");
        else
            $display("mesh_facet_statistics_unit regression: fail");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("mesh_facet_statistics_unit regression: fail");
        $finish;
    end
endmodule
